### rtl/prc_pkg.sv
`default_nettype none

package prc_pkg;

   localparam logic [7:0]  MAX_PACKET     = 8'd128;
   localparam logic [7:0]  MIN_PACKET     = 8'd6;
   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [7:0]  OWN_ADDR_RESET = 8'd78;

   localparam logic [7:0] CTRL_HELLO     = 8'h48;
   localparam logic [7:0] CTRL_NEIGHBOUR = 8'h4E;
   localparam logic [7:0] CTRL_MESSAGE   = 8'h4D;
   localparam logic [7:0] CTRL_SINGLE    = 8'h53;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   typedef enum logic [2:0] {
      KIND_CORRUPT   = 3'd0,
      KIND_HELLO     = 3'd1,
      KIND_NEIGHBOUR = 3'd2,
      KIND_FOR_ME    = 3'd3,
      KIND_FORWARD   = 3'd4,
      KIND_DROP      = 3'd5
   } packet_kind_type;

   // everything the back end needs to classify one finished packet
   typedef struct packed {
      logic [15:0] crc;
      logic [7:0]  tail_hi;
      logic [7:0]  tail_lo;
      logic [7:0]  count;
      logic        too_long;
      logic [7:0]  ctrl0;
      logic [7:0]  ctrl1;
      logic [7:0]  dest;
   } summary_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/prc_front.sv
`default_nettype none

module prc_front
   import prc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  data_byte,
   input  wire logic        last_byte,
   output      logic        sum_push,
   output      summary_type sum_data
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  dly0_ff, dly0_in;
   logic [7:0]  dly1_ff, dly1_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  ctrl0_ff, ctrl0_in;
   logic [7:0]  ctrl1_ff, ctrl1_in;
   logic [7:0]  dest_ff, dest_in;
   logic        too_long_ff, too_long_in;
   logic [15:0] crc_adj;

   always_comb begin
      // byte two places back leaves the delay line into the crc
      crc_in      = (count_ff >= 8'd2) ? crc_feed(crc_ff, dly1_ff) : crc_ff;
      dly1_in     = dly0_ff;
      dly0_in     = data_byte;
      ctrl0_in    = (count_ff == 8'd0) ? data_byte : ctrl0_ff;
      ctrl1_in    = (count_ff == 8'd1) ? data_byte : ctrl1_ff;
      dest_in     = (count_ff == 8'd3) ? data_byte : dest_ff;
      too_long_in = too_long_ff | (count_ff >= MAX_PACKET);
      count_in    = (count_ff >= MAX_PACKET) ? count_ff : count_ff + 8'd1;

      crc_adj = crc_in;
      if (crc_adj[15:8] == 8'h00) begin
         crc_adj[15:8] = 8'hFF;
      end
      if (crc_adj[7:0] == 8'h00) begin
         crc_adj[7:0] = 8'hFF;
      end
   end

   assign sum_push = accept & last_byte;

   always_comb begin
      sum_data.crc      = crc_adj;
      sum_data.tail_hi  = dly0_ff;
      sum_data.tail_lo  = data_byte;
      sum_data.count    = count_in;
      sum_data.too_long = too_long_in;
      sum_data.ctrl0    = ctrl0_in;
      sum_data.ctrl1    = ctrl1_in;
      sum_data.dest     = dest_in;
   end

   always_ff @(posedge clock) begin
      if (reset || sum_push) begin
         crc_ff      <= '0;
         dly0_ff     <= '0;
         dly1_ff     <= '0;
         count_ff    <= '0;
         ctrl0_ff    <= '0;
         ctrl1_ff    <= '0;
         dest_ff     <= '0;
         too_long_ff <= 1'b0;
      end else if (accept) begin
         crc_ff      <= crc_in;
         dly0_ff     <= dly0_in;
         dly1_ff     <= dly1_in;
         count_ff    <= count_in;
         ctrl0_ff    <= ctrl0_in;
         ctrl1_ff    <= ctrl1_in;
         dest_ff     <= dest_in;
         too_long_ff <= too_long_in;
      end
   end

endmodule

`default_nettype wire

### rtl/prc_fifo.sv
`default_nettype none

module prc_fifo
   import prc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire summary_type push_data,
   output      logic        full,
   input  wire logic        pop,
   output      summary_type pop_data,
   output      logic        empty
);

   summary_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]     count_ff, count_in;
   logic                    do_push, do_pop;

   assign full     = (count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/prc_back.sv
`default_nettype none

module prc_back
   import prc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  own_address,
   input  wire summary_type sum_data,
   input  wire logic        sum_empty,
   output      logic        sum_pop,
   output      logic        rsp_empty,
   input  wire logic        rsp_pop,
   output      logic [2:0]  rsp_packet_kind,
   output      logic [15:0] rsp_computed_crc,
   output      logic [7:0]  rsp_byte_count
);

   logic            valid_ff;
   packet_kind_type kind_ff, kind_in;
   logic [15:0]     crc_ff;
   logic [7:0]      count_ff;
   logic            crc_good;

   assign crc_good = (sum_data.tail_hi == sum_data.crc[15:8]) &&
                     (sum_data.tail_lo == sum_data.crc[7:0]);

   always_comb begin
      priority if (sum_data.too_long || sum_data.count < MIN_PACKET || !crc_good) begin
         kind_in = KIND_CORRUPT;
      end else if (sum_data.ctrl0 == CTRL_HELLO) begin
         kind_in = KIND_HELLO;
      end else if (sum_data.ctrl0 == CTRL_NEIGHBOUR) begin
         kind_in = KIND_NEIGHBOUR;
      end else if (sum_data.ctrl0 == CTRL_MESSAGE) begin
         priority if (sum_data.dest == own_address) begin
            kind_in = KIND_FOR_ME;
         end else if (sum_data.ctrl1 != CTRL_SINGLE) begin
            kind_in = KIND_FORWARD;
         end else begin
            kind_in = KIND_DROP;
         end
      end else begin
         // unknown control byte passes as hello
         kind_in = KIND_HELLO;
      end
   end

   // refill the output register when it is free or being taken
   assign sum_pop = ~sum_empty & (~valid_ff | rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sum_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_pop) begin
         kind_ff  <= kind_in;
         crc_ff   <= sum_data.crc;
         count_ff <= sum_data.count;
      end
   end

   assign rsp_empty        = ~valid_ff;
   assign rsp_packet_kind  = kind_ff;
   assign rsp_computed_crc = crc_ff;
   assign rsp_byte_count   = count_ff;

endmodule

`default_nettype wire

### rtl/packet_receive_classifier_top.sv
`default_nettype none

// Packet receive checker and classifier. Bytes of a packet are pushed one per
// cycle while req_full is low, with req_last_byte marking the final one; the
// front end runs a byte-parallel CRC-16 XModem over all but the two trailing
// bytes, so it takes one byte every cycle unless req_full holds it. At the
// last byte a packet summary goes into a two-entry queue, and the back end
// compares the adjusted CRC with the trailing bytes, classifies the packet and
// holds the result word in an output register, refilled from the queue when
// free or being read. req_full rises only when the queue holds two unread
// summaries. csr_wr_data sets this node's address; the user must write it only
// while no packet is in flight, as the block itself does not enforce this.
module packet_receive_classifier_top
   import prc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output      logic        req_full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output      logic        rsp_empty,
   input  wire logic        rsp_pop,
   output      logic [2:0]  rsp_packet_kind,
   output      logic [15:0] rsp_computed_crc,
   output      logic [7:0]  rsp_byte_count,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   logic [7:0]  own_addr_ff;
   logic        req_accept;
   logic        sum_push, sum_pop, sum_empty;
   summary_type sum_in_data, sum_out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= OWN_ADDR_RESET;
      end else if (csr_wr_en) begin
         own_addr_ff <= csr_wr_data;
      end
   end

   assign req_accept = req_push & ~req_full;

   prc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .sum_push  (sum_push),
      .sum_data  (sum_in_data)
   );

   prc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (sum_push),
      .push_data (sum_in_data),
      .full      (req_full),
      .pop       (sum_pop),
      .pop_data  (sum_out_data),
      .empty     (sum_empty)
   );

   prc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .own_address      (own_addr_ff),
      .sum_data         (sum_out_data),
      .sum_empty        (sum_empty),
      .sum_pop          (sum_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_packet_kind  (rsp_packet_kind),
      .rsp_computed_crc (rsp_computed_crc),
      .rsp_byte_count   (rsp_byte_count)
   );

   // only valid kinds and counts reach the result port
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_packet_kind <= KIND_DROP) && (rsp_byte_count <= MAX_PACKET)
                     && (rsp_byte_count != 8'd0))
      else $error("result word out of range");

   // a packet accepted as good is never short and never longer than MAX_PACKET
   a_good_len: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_packet_kind != KIND_CORRUPT) |->
         (rsp_byte_count >= MIN_PACKET) && (rsp_byte_count < MAX_PACKET + 8'd1))
      else $error("good packet with bad length");

   // adjusted crc never has a zero byte
   a_crc_adj: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_computed_crc[15:8] != 8'h00) && (rsp_computed_crc[7:0] != 8'h00))
      else $error("crc zero-byte substitution missed");

endmodule

`default_nettype wire

### tb/prc_verdict_checker.sv
// watches both channels of the packet classifier, predicts each verdict and
// compares it with what comes out
module prc_verdict_checker
   import prc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [2:0]  rsp_packet_kind,
   input  logic [15:0] rsp_computed_crc,
   input  logic [7:0]  rsp_byte_count,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output int          fail_count,
   output int          outstanding
);

   typedef struct packed {
      packet_kind_type kind;
      logic [15:0]     crc;
      logic [7:0]      count;
   } verdict_type;

   verdict_type verdicts_due[$];

   // mirror of the receive state
   logic [15:0] crc_acc;
   logic [7:0]  held_newest;
   logic [7:0]  held_oldest;
   logic [7:0]  seen_count;
   logic [7:0]  ctrl_first;
   logic [7:0]  ctrl_second;
   logic [7:0]  dest_addr;
   logic        overlong;
   logic [7:0]  node_addr;
   int          errors = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic logic [15:0] crc_shift_in(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ d[i];
         r  = {r[14:0], 1'b0};
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   task automatic clear_packet();
      crc_acc     = '0;
      held_newest = '0;
      held_oldest = '0;
      seen_count  = '0;
      ctrl_first  = '0;
      ctrl_second = '0;
      dest_addr   = '0;
      overlong    = 1'b0;
   endtask

   task automatic absorb_byte(input logic [7:0] b, input logic last);
      logic [7:0]      pos;
      logic [7:0]      prev;
      logic [15:0]     adj;
      packet_kind_type k;
      verdict_type     v;
      pos  = seen_count;
      prev = held_newest;
      // the byte two places back is the first one known not to be crc
      if (pos >= 8'd2) begin
         crc_acc = crc_shift_in(crc_acc, held_oldest);
      end
      held_oldest = held_newest;
      held_newest = b;
      case (pos)
         8'd0: ctrl_first = b;
         8'd1: ctrl_second = b;
         8'd3: dest_addr = b;
         default: ;
      endcase
      if (seen_count >= MAX_PACKET) begin
         overlong = 1'b1;
      end else begin
         seen_count = seen_count + 8'd1;
      end
      if (last) begin
         adj = crc_acc;
         if (adj[15:8] == 8'h00) adj[15:8] = 8'hFF;
         if (adj[7:0] == 8'h00) adj[7:0] = 8'hFF;
         if (overlong || seen_count < MIN_PACKET || prev != adj[15:8] || b != adj[7:0]) begin
            k = KIND_CORRUPT;
         end else if (ctrl_first == CTRL_NEIGHBOUR) begin
            k = KIND_NEIGHBOUR;
         end else if (ctrl_first == CTRL_MESSAGE) begin
            if (dest_addr == node_addr) begin
               k = KIND_FOR_ME;
            end else if (ctrl_second != CTRL_SINGLE) begin
               k = KIND_FORWARD;
            end else begin
               k = KIND_DROP;
            end
         end else begin
            // hello, and any unrecognised control byte
            k = KIND_HELLO;
         end
         v.kind  = k;
         v.crc   = adj;
         v.count = seen_count;
         verdicts_due.push_back(v);
         clear_packet();
      end
   endtask

   task automatic check_word();
      verdict_type v;
      if (verdicts_due.size() == 0) begin
         $display("%0t: unexpected word: kind %0d crc %h count %0d", $time,
                  rsp_packet_kind, rsp_computed_crc, rsp_byte_count);
         errors++;
      end else begin
         v = verdicts_due.pop_front();
         if (rsp_packet_kind !== v.kind) begin
            $display("%0t: packet_kind expected %0d, got %0d", $time, v.kind, rsp_packet_kind);
            errors++;
         end
         if (rsp_computed_crc !== v.crc) begin
            $display("%0t: computed_crc expected %h, got %h", $time, v.crc, rsp_computed_crc);
            errors++;
         end
         if (rsp_byte_count !== v.count) begin
            $display("%0t: byte_count expected %0d, got %0d", $time, v.count, rsp_byte_count);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_packet();
         node_addr = OWN_ADDR_RESET;
         verdicts_due.delete();
      end else begin
         if (csr_wr_en) begin
            node_addr = csr_wr_data;
         end
         // an older word leaves before a new packet end can add one
         if (rsp_pop && !rsp_empty) begin
            check_word();
         end
         if (req_push && !req_full) begin
            absorb_byte(req_data_byte, req_last_byte);
         end
      end
      outstanding <= verdicts_due.size();
      fail_count  <= errors;
   end

endmodule

### tb/packet_receive_classifier_top_test.sv
module packet_receive_classifier_top_test;
   import prc_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int BYTES_WANTED = 1050;
   localparam int IDLE_PCT     = 27;

   typedef logic [7:0] byte_q_type[$];

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_push      = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop       = 1'b0;
   logic [2:0]  rsp_packet_kind;
   logic [15:0] rsp_computed_crc;
   logic [7:0]  rsp_byte_count;
   logic        csr_wr_en     = 1'b0;
   logic [7:0]  csr_wr_data   = 8'h00;

   int          fails;
   int          outstanding;
   int          quiet_cycles  = 0;
   int          bytes_sent    = 0;
   bit          calm          = 1'b0;
   logic [7:0]  node_addr     = OWN_ADDR_RESET;

   packet_receive_classifier_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_packet_kind  (rsp_packet_kind),
      .rsp_computed_crc (rsp_computed_crc),
      .rsp_byte_count   (rsp_byte_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   prc_verdict_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_packet_kind  (rsp_packet_kind),
      .rsp_computed_crc (rsp_computed_crc),
      .rsp_byte_count   (rsp_byte_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fails),
      .outstanding      (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // crc over the first n bytes, before the zero-byte substitution
   function automatic logic [15:0] raw_crc(input byte_q_type p, input int n);
      logic [15:0] c;
      c = 16'h0000;
      for (int i = 0; i < n; i++) begin
         c = c ^ {p[i], 8'h00};
         for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // well-formed packet with a matching crc trailer; zero_hunt steers the
   // last body byte so that the crc has a zero byte to be substituted
   function automatic byte_q_type good_packet(input logic [7:0] ctrl0, input logic [7:0] ctrl1,
                                              input logic [7:0] dest, input int len,
                                              input bit zero_hunt);
      byte_q_type  p;
      logic [15:0] c;
      p = {};
      p.push_back(ctrl0);
      p.push_back(ctrl1);
      p.push_back(8'($urandom));
      p.push_back(dest);
      while (p.size() < len - 2) begin
         p.push_back(8'($urandom));
      end
      if (zero_hunt && len >= 8) begin
         for (int v = 0; v < 256; v++) begin
            p[len - 3] = 8'(v);
            c = raw_crc(p, len - 2);
            if (c[15:8] == 8'h00 || c[7:0] == 8'h00) break;
         end
      end
      c = raw_crc(p, len - 2);
      if (c[15:8] == 8'h00) c[15:8] = 8'hFF;
      if (c[7:0] == 8'h00) c[7:0] = 8'hFF;
      p.push_back(c[15:8]);
      p.push_back(c[7:0]);
      return p;
   endfunction

   function automatic byte_q_type junk_packet(input int len);
      byte_q_type p;
      p = {};
      repeat (len) p.push_back(8'($urandom));
      return p;
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic last);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   task automatic send_packet(input byte_q_type p);
      for (int i = 0; i < p.size(); i++) begin
         put_byte(p[i], i == p.size() - 1);
      end
   endtask

   // address changes only with nothing in flight
   task automatic change_address(input logic [7:0] a);
      req_push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= a;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      node_addr = a;
   endtask

   initial begin
      byte_q_type  pkt;
      int          r;
      int          next_switch;
      int          switches;
      logic [7:0]  c0;
      logic [7:0]  c1;
      logic [7:0]  dst;
      int          len;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short packets, every kind, unknown control, zero substitution
      pkt = {8'hFF};
      send_packet(pkt);
      pkt = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_packet(pkt);
      send_packet(good_packet(CTRL_HELLO, 8'h00, 8'hFF, 6, 1'b0));
      send_packet(good_packet(CTRL_NEIGHBOUR, 8'hFF, 8'h00, 6, 1'b0));
      send_packet(good_packet(CTRL_MESSAGE, 8'h00, OWN_ADDR_RESET, 6, 1'b0));
      send_packet(good_packet(CTRL_MESSAGE, 8'h01, 8'h4F, 6, 1'b0));
      send_packet(good_packet(CTRL_MESSAGE, CTRL_SINGLE, 8'h4F, 6, 1'b0));
      send_packet(good_packet(8'h00, 8'h00, 8'h00, 8, 1'b1));

      next_switch = 200;
      switches    = 0;
      while (bytes_sent < BYTES_WANTED) begin
         if (bytes_sent >= next_switch) begin
            case (switches)
               0: change_address(8'h00);
               1: change_address(8'hFF);
               2: change_address(8'($urandom));
               default: change_address(OWN_ADDR_RESET);
            endcase
            switches++;
            next_switch += 240;
         end
         calm = (bytes_sent >= 480 && bytes_sent < 700);

         case ($urandom_range(5))
            0: c0 = CTRL_HELLO;
            1: c0 = CTRL_NEIGHBOUR;
            2, 3: c0 = CTRL_MESSAGE;
            default: c0 = 8'($urandom);
         endcase
         c1  = $urandom_range(1) ? CTRL_SINGLE : 8'($urandom);
         dst = $urandom_range(1) ? node_addr : 8'($urandom);
         len = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(6, 16);

         r = $urandom_range(99);
         if (r < 60) begin
            pkt = good_packet(c0, c1, dst, len, $urandom_range(7) == 0);
         end else if (r < 72) begin
            // one flipped bit anywhere in an otherwise good packet
            pkt = good_packet(c0, c1, dst, len, 1'b0);
            r = $urandom_range(pkt.size() - 1);
            pkt[r] = pkt[r] ^ (8'h01 << $urandom_range(7));
         end else if (r < 82) begin
            pkt = junk_packet($urandom_range(1, 5));
         end else if (r < 86) begin
            pkt = good_packet(c0, c1, dst, $urandom_range(129, 140), 1'b0);
         end else if (r < 88) begin
            pkt = good_packet(c0, c1, dst, int'(MAX_PACKET), 1'b0);
         end else begin
            pkt = junk_packet($urandom_range(6, 20));
         end
         send_packet(pkt);
      end

      calm = 1'b0;
      req_push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
      if (fails == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
